// ===== src/html_entity_decoder_macros.svh =====
// Assertion macros shared by the HTML entity decoder modules.
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

// The condition must never hold outside reset.
`define HED_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("decoder check failed: forbidden condition seen");

// Whenever the first condition holds, the second holds in the same cycle.
`define HED_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed: implication broken");

// Whenever the first condition holds, the second holds in the next cycle.
`define HED_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed: next-cycle implication broken");

`endif

// ===== src/hed_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the HTML entity decoder modules.
package hed_pkg;

  localparam int PEND_DEPTH     = 10;
  localparam int WORK_DEPTH     = 11;
  localparam int HEX_DIGITS_MAX = 7;
  localparam int DEC_DIGITS_MAX = 8;
  localparam int CP_W           = 28;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int ENT_COUNT      = 5;

  localparam logic [ADDR_W-3:0] REG_NUMERIC_ENABLE = '0;

  localparam logic [CP_W-1:0] CODE_LIMIT = 28'h0110000;
  localparam logic [CP_W-1:0] UTF_LIM1   = 28'h0000080;
  localparam logic [CP_W-1:0] UTF_LIM2   = 28'h0000800;
  localparam logic [CP_W-1:0] UTF_LIM3   = 28'h0010000;

  localparam logic [7:0] UTF_CONT_MASK = 8'h3f;
  localparam logic [7:0] UTF_LEAD4     = 8'hf0;
  localparam logic [7:0] UTF_LEAD3     = 8'he0;
  localparam logic [7:0] UTF_LEAD2     = 8'hc0;
  localparam logic [7:0] UTF_CONT      = 8'h80;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  // Entity names, leading ampersand in the top byte, padded with zero bytes.
  typedef logic [5:0][7:0] ent_name_t;
  localparam ent_name_t ENT_NAME [ENT_COUNT] = '{
    "&quot;", {"&amp;", 8'h00}, "&apos;", {"&lt;", 16'h0000}, {"&gt;", 16'h0000}
  };
  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd6, 3'd5, 3'd6, 3'd4, 3'd4};
  localparam logic [7:0] ENT_VAL [ENT_COUNT] = '{8'h22, 8'h26, 8'h27, 8'h3c, 8'h3e};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        stream_end;
    logic [15:0] replacements;
  } result_t;

  typedef logic [WORK_DEPTH-1:0][7:0] work_t;

  typedef struct packed {
    work_t       bytes;
    logic [3:0]  count;
    logic        last;
    logic [15:0] total;
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_FAIL,
    CLS_PREFIX,
    CLS_MATCH
  } cls_t;

endpackage

// ===== src/hed_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the pending candidate, classifies each byte and issues output bursts.
`include "html_entity_decoder_macros.svh"
module hed_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           numeric_enable,
  input  logic           take,
  input  hed_pkg::item_t item,
  output logic           cmd_push,
  output hed_pkg::cmd_t  cmd
);
  import hed_pkg::*;

  logic [7:0]           pend [PEND_DEPTH];
  logic [3:0]           pend_count, pend_count_next;
  logic [ENT_COUNT-1:0] alive, alive_next;
  logic [CP_W-1:0]      cp, cp_next;
  logic [15:0]          total, total_next;

  logic [7:0]           c;
  logic                 last;
  logic [3:0]           n;
  work_t                work;
  logic                 hash_cand, is_hex, numeric, dec_ok, hex_ok, dig_ok;
  logic [3:0]           v, ndig, maxd;
  logic [CP_W-1:0]      cp_step;
  logic [ENT_COUNT-1:0] step_alive, ent_done;
  logic [7:0]           named_val;
  work_t                rep;
  logic [3:0]           rep_len;
  cls_t                 cls;
  logic                 pend_we;
  logic [3:0]           pend_wpos;
  logic                 total_inc;
  logic [15:0]          total_after;

  assign c    = item.in_byte;
  assign last = item.in_last;
  assign n    = pend_count;

  always_comb begin
    for (int k = 0; k < PEND_DEPTH; k++) begin
      work[k] = (4'(k) < n) ? pend[k] : c;
    end
    work[PEND_DEPTH] = c;
  end

  always_comb begin
    hash_cand = (n >= 4'd2) && (pend[1] == CH_HASH);
    is_hex    = (n >= 4'd3) && (pend[2] == CH_LOWER_X);
    dec_ok    = c inside {[CH_DIGIT_0:CH_DIGIT_9]};
    hex_ok    = dec_ok || (c inside {[CH_UPPER_A:CH_UPPER_F], [CH_LOWER_A:CH_LOWER_F]});
    dig_ok    = is_hex ? hex_ok : dec_ok;
    v         = dec_ok ? c[3:0] : c[3:0] + 4'd9;
    ndig      = n - (is_hex ? 4'd3 : 4'd2);
    maxd      = is_hex ? 4'(HEX_DIGITS_MAX) : 4'(DEC_DIGITS_MAX);
    cp_step   = is_hex ? {cp[CP_W-5:0], v} : (cp << 3) + (cp << 1) + CP_W'(v);
    numeric   = numeric_enable && ((n == 4'd1) ? (c == CH_HASH) : hash_cand);
  end

  always_comb begin
    named_val = '0;
    for (int i = 0; i < ENT_COUNT; i++) begin
      step_alive[i] = 1'b0;
      for (int k = 1; k < 6; k++) begin
        if (n == 4'(k) && ENT_NAME[i][5-k] == c && 3'(k) < ENT_LEN[i]) begin
          step_alive[i] = alive[i];
        end
      end
      ent_done[i] = step_alive[i] && (ENT_LEN[i] == 3'(n + 4'd1));
      if (ent_done[i]) begin
        named_val = named_val | ENT_VAL[i];
      end
    end
  end

  always_comb begin
    rep     = '0;
    rep_len = 4'd1;
    if (!numeric) begin
      rep[0] = named_val;
    end else if (cp < UTF_LIM1) begin
      rep[0] = cp[7:0];
    end else if (cp < UTF_LIM2) begin
      rep[0]  = UTF_LEAD2 | {3'b000, cp[10:6]};
      rep[1]  = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
      rep_len = 4'd2;
    end else if (cp < UTF_LIM3) begin
      rep[0]  = UTF_LEAD3 | {4'b0000, cp[15:12]};
      rep[1]  = UTF_CONT | (cp[13:6] & UTF_CONT_MASK);
      rep[2]  = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
      rep_len = 4'd3;
    end else begin
      rep[0]  = UTF_LEAD4 | {5'b00000, cp[20:18]};
      rep[1]  = UTF_CONT | (cp[19:12] & UTF_CONT_MASK);
      rep[2]  = UTF_CONT | (cp[13:6] & UTF_CONT_MASK);
      rep[3]  = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
      rep_len = 4'd4;
    end
  end

  always_comb begin
    if (numeric) begin
      if (n == 4'd1 || (n == 4'd2 && c == CH_LOWER_X)) begin
        cls = CLS_PREFIX;
      end else if (dig_ok) begin
        cls = (ndig >= maxd) ? CLS_FAIL : CLS_PREFIX;
      end else if (c == CH_SEMI && ndig != 4'd0 && cp < CODE_LIMIT) begin
        cls = CLS_MATCH;
      end else begin
        cls = CLS_FAIL;
      end
    end else if (|ent_done) begin
      cls = CLS_MATCH;
    end else if (|step_alive) begin
      cls = CLS_PREFIX;
    end else begin
      cls = CLS_FAIL;
    end
  end

  assign total_inc   = (n != 4'd0) && (cls == CLS_MATCH);
  assign total_after = (total_inc && total != '1) ? total + 16'd1 : total;

  always_comb begin
    cmd_push        = 1'b0;
    cmd.bytes       = work;
    cmd.count       = n + 4'd1;
    cmd.last        = last;
    cmd.total       = total_after;
    pend_we         = 1'b0;
    pend_wpos       = '0;
    pend_count_next = pend_count;
    alive_next      = alive;
    cp_next         = cp;
    total_next      = total;
    if (take) begin
      total_next = last ? '0 : total_after;
      if (n == 4'd0) begin
        if (c == CH_AMP && !last) begin
          pend_we         = 1'b1;
          pend_count_next = 4'd1;
          alive_next      = '1;
          cp_next         = '0;
        end else begin
          cmd_push = 1'b1;
        end
      end else begin
        case (cls)
          CLS_PREFIX: begin
            if (last) begin
              cmd_push = 1'b1;
            end else begin
              pend_we         = 1'b1;
              pend_wpos       = n;
              pend_count_next = n + 4'd1;
              alive_next      = step_alive;
              cp_next         = (numeric && dig_ok) ? cp_step : cp;
            end
          end
          CLS_MATCH: begin
            cmd_push        = 1'b1;
            cmd.bytes       = rep;
            cmd.count       = rep_len;
            pend_count_next = '0;
            cp_next         = '0;
          end
          default: begin
            cmd_push = 1'b1;
            cp_next  = '0;
            if (c == CH_AMP && !last) begin
              cmd.count       = n;
              pend_we         = 1'b1;
              pend_count_next = 4'd1;
              alive_next      = '1;
            end else begin
              pend_count_next = '0;
            end
          end
        endcase
      end
      if (last) begin
        pend_count_next = '0;
        cp_next         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      alive      <= '0;
      cp         <= '0;
      total      <= '0;
    end else begin
      pend_count <= pend_count_next;
      alive      <= alive_next;
      cp         <= cp_next;
      total      <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PEND_DEPTH; k++) begin
      if (pend_we && pend_wpos == 4'(k)) begin
        pend[k] <= c;
      end
    end
  end

  `HED_ASSERT_NEVER(a_pend_bound, clk, rst, pend_count > 4'(PEND_DEPTH))

endmodule

// ===== src/hed_queue.sv =====
`timescale 1ns / 1ps
// Short queue of output bursts between the front end and the back end.
`include "html_entity_decoder_macros.svh"
module hed_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hed_pkg::cmd_t wdata,
  input  logic          pop,
  output hed_pkg::cmd_t rdata,
  output logic          full,
  output logic          valid
);
  import hed_pkg::*;

  cmd_t              slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] count, count_next;

  assign rdata = slot[rd_ptr];
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);

  always_comb begin
    wr_ptr_next = push ? wr_ptr + 1'b1 : wr_ptr;
    rd_ptr_next = pop ? rd_ptr + 1'b1 : rd_ptr;
    count_next  = count + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  `HED_ASSERT_NEVER(a_no_overflow, clk, rst, push && full)
  `HED_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, pop, count != '0)
  `HED_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, count != '0)

endmodule

// ===== src/hed_back.sv =====
`timescale 1ns / 1ps
// Back end: plays each queued burst out one byte per beat and marks its ends.
module hed_back (
  input  logic             clk,
  input  logic             rst,
  input  hed_pkg::cmd_t    head,
  input  logic             head_valid,
  output logic             head_pop,
  input  logic             pop,
  output logic             empty,
  output hed_pkg::result_t result
);
  import hed_pkg::*;

  logic [3:0] idx, idx_next;
  logic       at_end;

  assign at_end = (idx == head.count - 4'd1);
  assign empty  = !head_valid;

  always_comb begin
    result.out_byte     = head.bytes[idx];
    result.run_last     = at_end;
    result.stream_end   = at_end && head.last;
    result.replacements = (at_end && head.last) ? head.total : '0;
    head_pop            = pop && head_valid && at_end;
    idx_next            = idx;
    if (pop && head_valid) begin
      idx_next = at_end ? '0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

// ===== src/html_entity_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the streaming HTML entity decoder.
// Input bytes enter as beats on push/full; a beat is taken when push is high and full is low.
// Decoded bytes leave as beats on empty/pop; the oldest byte is shown while empty is low.
// The front end takes one input beat per cycle whenever the internal burst queue (two
// entries) has room; a byte that only extends a pending entity produces no output.
// Each input that resolves gives a burst of 1 to 11 output bytes, which waits in the burst
// queue and is played out at one byte per cycle while the receiver holds pop high.
// run_last marks the last byte of each burst; stream_end and the replacement count come
// with the final byte of the text.
// When the receiver holds pop low the queue fills and full rises; nothing is lost.
// The APB port holds numeric_refs_enable at address 0; change it only while idle.
// Reset empties the queue, drops any pending candidate, clears the count and sets
// numeric references on.
module html_entity_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  hed_pkg::item_t               item,
  output logic                         empty,
  input  logic                         pop,
  output hed_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hed_pkg::ADDR_W-1:0]   paddr,
  input  logic [hed_pkg::DATA_W-1:0]   pwdata,
  output logic [hed_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import hed_pkg::*;

  logic numeric_refs_enable;
  logic reg_hit;
  logic take;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic head_valid;
  logic head_pop;
  logic q_full;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_NUMERIC_ENABLE);
  assign prdata  = reg_hit ? {{(DATA_W-1){1'b0}}, numeric_refs_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      numeric_refs_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      numeric_refs_enable <= pwdata[0];
    end
  end

  assign full = q_full;
  assign take = push && !q_full;

  hed_front u_front (
    .clk            (clk),
    .rst            (rst),
    .numeric_enable (numeric_refs_enable),
    .take           (take),
    .item           (item),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  hed_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .pop   (head_pop),
    .rdata (head),
    .full  (q_full),
    .valid (head_valid)
  );

  hed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

// ===== dv/tb_html_entity_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for html_entity_decoder: directed text table, random texts, scoreboard.
module tb_html_entity_decoder;
  import hed_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 61;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [ADDR_W-1:0] NUMERIC_ADDR = {REG_NUMERIC_ENABLE, 2'b00};

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Mirror of the decoder state.
  bit numeric_on = 1'b1;
  logic [PEND_DEPTH-1:0][7:0] pend_bytes = '0;
  int pend_n = 0;
  logic [15:0] replaced_count = '0;

  string ent_names[ENT_COUNT];
  logic [7:0] ent_chars[ENT_COUNT];

  result_t decoded_q[$];
  result_t fresh_q[$];
  row_t dir_rows[$];
  logic [7:0] tok_q[$];

  bit calm = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int texts_done = 0;
  int mode_writes = 0;
  int quiet = 0;

  html_entity_decoder dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= 30) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Judges the candidate that starts with the ampersand at position at and spans n bytes.
  function automatic cls_t judge_ref(input work_t w, input int at, input int n,
                                     output logic [3:0][7:0] rep, output int rep_n);
    int e, j, len, dstart, limit, base, v;
    bit same;
    logic [31:0] cp;
    logic [7:0] c;
    rep = '0;
    rep_n = 0;
    cp = '0;
    if (n <= 1) return CLS_PREFIX;
    if (!(numeric_on && w[at+1] == CH_HASH)) begin
      for (e = 0; e < ENT_COUNT; e++) begin
        len = ent_names[e].len();
        same = (n <= len);
        for (j = 0; j < n && same; j++)
          if (w[at+j] != ent_names[e][j]) same = 1'b0;
        if (same) begin
          if (n < len) return CLS_PREFIX;
          rep[0] = ent_chars[e];
          rep_n = 1;
          return CLS_MATCH;
        end
      end
      return CLS_FAIL;
    end
    if (n == 2) return CLS_PREFIX;
    if (w[at+2] == CH_LOWER_X) begin
      dstart = 3;
      limit = HEX_DIGITS_MAX;
      base = 16;
    end else begin
      dstart = 2;
      limit = DEC_DIGITS_MAX;
      base = 10;
    end
    for (j = dstart; j < n; j++) begin
      c = w[at+j];
      v = -1;
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) v = int'(c - CH_DIGIT_0);
      else if (base == 16 && c >= CH_UPPER_A && c <= CH_UPPER_F)
        v = int'(c - CH_UPPER_A) + 10;
      else if (base == 16 && c >= CH_LOWER_A && c <= CH_LOWER_F)
        v = int'(c - CH_LOWER_A) + 10;
      if (v >= 0) begin
        if (j - dstart >= limit) return CLS_FAIL;
        cp = cp * base + v;
      end else if (c == CH_SEMI && j == n - 1 && j > dstart) begin
        if (cp >= CODE_LIMIT) return CLS_FAIL;
        if (cp < UTF_LIM1) begin
          rep[0] = cp[7:0];
          rep_n = 1;
        end else if (cp < UTF_LIM2) begin
          rep[0] = UTF_LEAD2 | cp[13:6];
          rep[1] = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
          rep_n = 2;
        end else if (cp < UTF_LIM3) begin
          rep[0] = UTF_LEAD3 | cp[19:12];
          rep[1] = UTF_CONT | (cp[13:6] & UTF_CONT_MASK);
          rep[2] = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
          rep_n = 3;
        end else begin
          rep[0] = UTF_LEAD4 | {5'b0, cp[20:18]};
          rep[1] = UTF_CONT | (cp[19:12] & UTF_CONT_MASK);
          rep[2] = UTF_CONT | (cp[13:6] & UTF_CONT_MASK);
          rep[3] = UTF_CONT | (cp[7:0] & UTF_CONT_MASK);
          rep_n = 4;
        end
        return CLS_MATCH;
      end else begin
        return CLS_FAIL;
      end
    end
    return CLS_PREFIX;
  endfunction

  // Works out the decoded bytes caused by one input beat and leaves them in fresh_q.
  task automatic decode_item(input item_t it);
    work_t w;
    logic [WORK_DEPTH-1:0][7:0] emit;
    logic [3:0][7:0] rep;
    result_t r;
    cls_t verdict;
    int wn, pos, ne, j, rep_n, rem;
    bit held;
    w = '0;
    emit = '0;
    for (j = 0; j < pend_n; j++) w[j] = pend_bytes[j];
    w[pend_n] = it.in_byte;
    wn = pend_n + 1;
    pos = 0;
    ne = 0;
    held = 1'b0;
    while (pos < wn && !held) begin
      if (w[pos] != CH_AMP) begin
        emit[ne] = w[pos];
        ne++;
        pos++;
      end else begin
        verdict = judge_ref(w, pos, wn - pos, rep, rep_n);
        if (verdict == CLS_MATCH) begin
          for (j = 0; j < rep_n && ne < WORK_DEPTH; j++) begin
            emit[ne] = rep[j];
            ne++;
          end
          if (replaced_count != 16'hffff) replaced_count++;
          pos = wn;
        end else if (verdict == CLS_PREFIX) begin
          held = 1'b1;
        end else begin
          emit[ne] = CH_AMP;
          ne++;
          pos++;
        end
      end
    end
    if (it.in_last) begin
      while (pos < wn) begin
        emit[ne] = w[pos];
        ne++;
        pos++;
      end
      pend_n = 0;
    end else begin
      rem = wn - pos;
      if (rem > PEND_DEPTH) rem = PEND_DEPTH;
      for (j = 0; j < rem; j++) pend_bytes[j] = w[pos+j];
      pend_n = rem;
    end
    for (j = 0; j < ne; j++) begin
      r.out_byte = emit[j];
      r.run_last = (j == ne - 1);
      r.stream_end = (j == ne - 1) && it.in_last;
      r.replacements = r.stream_end ? replaced_count : 16'd0;
      fresh_q.push_back(r);
    end
    if (it.in_last) replaced_count = '0;
  endtask

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    fresh_q.delete();
    decode_item(it);
    if (typed) decoded_q.push_back(want);
    else while (fresh_q.size() != 0) decoded_q.push_back(fresh_q.pop_front());
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_numeric_enable(input logic on);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= NUMERIC_ADDR;
    pwdata <= {{(DATA_W-1){1'b0}}, on};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    numeric_on = on;
    mode_writes++;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(DATA_W-1){1'b0}}, on})
      flag_mismatch($sformatf("register read back %h, written %0d", prdata, on));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input logic typed,
                         input result_t want);
    row_t r;
    r.it.in_byte = b;
    r.it.in_last = last;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic add_text(input string s, input bit close);
    int j;
    for (j = 0; j < s.len(); j++) add_row(s[j], close && j == s.len() - 1, 1'b0, '0);
  endtask

  // One random fragment: plain bytes, a named entity or a numeric reference, often damaged.
  task automatic build_token();
    int kind, n, j, e, v;
    bit hex;
    logic [7:0] b;
    tok_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      n = $urandom_range(1, 4);
      for (j = 0; j < n; j++) begin
        b = 8'($urandom_range(0, 255));
        tok_q.push_back(b);
      end
    end else if (kind < 5) begin
      e = $urandom_range(0, ENT_COUNT - 1);
      n = ent_names[e].len();
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
      for (j = 0; j < n; j++) tok_q.push_back(ent_names[e][j]);
      if (n > 1 && $urandom_range(0, 7) == 0) begin
        b = 8'($urandom_range(0, 255));
        tok_q[$urandom_range(1, n - 1)] = b;
      end
    end else begin
      hex = (kind >= 7);
      tok_q.push_back(CH_AMP);
      tok_q.push_back(CH_HASH);
      if (hex) tok_q.push_back(($urandom_range(0, 9) == 0) ? CH_UPPER_X : CH_LOWER_X);
      n = $urandom_range(0, hex ? HEX_DIGITS_MAX + 1 : DEC_DIGITS_MAX + 1);
      for (j = 0; j < n; j++) begin
        v = $urandom_range(0, hex ? 21 : 9);
        if (v < 10) b = CH_DIGIT_0 + 8'(v);
        else if (v < 16) b = CH_LOWER_A + 8'(v - 10);
        else b = CH_UPPER_A + 8'(v - 16);
        tok_q.push_back(b);
      end
      b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_SEMI;
      tok_q.push_back(b);
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("output beat %h with nothing expected", result));
      end else begin
        want = decoded_q.pop_front();
        if (result.out_byte !== want.out_byte)
          flag_mismatch($sformatf("out_byte %h, expected %h", result.out_byte, want.out_byte));
        if (result.run_last !== want.run_last)
          flag_mismatch($sformatf("run_last %b, expected %b", result.run_last, want.run_last));
        if (result.stream_end !== want.stream_end)
          flag_mismatch($sformatf("stream_end %b, expected %b",
                                  result.stream_end, want.stream_end));
        if (result.replacements !== want.replacements)
          flag_mismatch($sformatf("replacements %0d, expected %0d",
                                  result.replacements, want.replacements));
        beats_checked++;
        if (want.stream_end) texts_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d still expected",
               QUIET_LIMIT, decoded_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int r, p, j, sent, flip_at;
    item_t it;
    ent_names[0] = "&quot;";
    ent_names[1] = "&amp;";
    ent_names[2] = "&apos;";
    ent_names[3] = "&lt;";
    ent_names[4] = "&gt;";
    ent_chars[0] = 8'h22;
    ent_chars[1] = CH_AMP;
    ent_chars[2] = 8'h27;
    ent_chars[3] = 8'h3c;
    ent_chars[4] = 8'h3e;

    add_row(8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b0, 16'd0});
    add_row(8'hff, 1'b0, 1'b1, {8'hff, 1'b1, 1'b0, 16'd0});
    add_text("&amp", 1'b0);
    add_row(CH_SEMI, 1'b0, 1'b1, {CH_AMP, 1'b1, 1'b0, 16'd0});
    add_text("&#0;", 1'b0);
    add_text("&#xAf;", 1'b0);
    add_text("&#X", 1'b0);
    add_text("&#;", 1'b0);
    add_text("&#", 1'b0);
    // Numeric decoding is switched off while the candidate above is still pending.
    flip_at = dir_rows.size();
    add_text("x", 1'b0);
    add_row(CH_SEMI, 1'b1, 1'b1, {CH_SEMI, 1'b1, 1'b1, 16'd3});
    add_text("&l", 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_numeric_enable(1'b1);
    for (r = 0; r < dir_rows.size(); r++) begin
      if (r == flip_at) begin
        wait_idle();
        write_numeric_enable(1'b0);
      end
      send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
    end

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      calm = (p == 2 || p == 4);
      if (p == 1 || p == 4) write_numeric_enable(1'b0);
      else if (p == PHASES - 1) write_numeric_enable(1'($urandom_range(0, 1)));
      else write_numeric_enable(1'b1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_token();
        for (j = 0; j < tok_q.size(); j++) begin
          it.in_byte = tok_q[j];
          it.in_last = ($urandom_range(0, 29) == 0);
          send_item(it, 1'b0, '0);
          sent++;
        end
      end
    end
    calm = 1'b0;
    wait_idle();

    $display("Sent %0d input beats and checked %0d output beats over %0d finished texts.",
             items_sent, beats_checked, texts_done);
    $display("Numeric decoding was written %0d times; %0d mismatches were seen.",
             mode_writes, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
